// ===== sv/ptt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Types, codes and defaults shared by the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int SLOTS_DEF = 16;

	localparam int NOW_W     = 40;
	localparam int PERIOD_W  = 32;
	localparam int ID_W      = 32;
	localparam int HANDLER_W = 16;
	localparam int CMD_W     = 2;
	localparam int KIND_W    = 3;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FULL      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DELETED   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NOMATCH   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [NOW_W-1:0]     now_ms;
		logic [PERIOD_W-1:0]  period_ms;
		logic [ID_W-1:0]      timer_id;
		logic [HANDLER_W-1:0] handler_tag;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [ID_W-1:0]      fired_id;
		logic [HANDLER_W-1:0] fired_handler;
		logic                 last;
	} rsp_t;

	// Command token walking down the cell row
	typedef struct packed {
		logic                 valid;
		logic [CMD_W-1:0]     cmd;
		logic                 stamp;   // first tick: stamp only, no firing
		logic                 flag;    // add: slot taken; delete: any cleared
		logic [NOW_W-1:0]     now_ms;
		logic [PERIOD_W-1:0]  period_ms;
		logic [ID_W-1:0]      timer_id;
		logic [HANDLER_W-1:0] handler_tag;
	} token_t;

	// Firing report from one cell; id and handler are zero when not firing
	typedef struct packed {
		logic                 fire;
		logic [ID_W-1:0]      id;
		logic [HANDLER_W-1:0] handler;
	} fire_t;

endpackage

// ===== sv/ptt_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface ptt_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ptt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_cell
// One timer slot; handles the token passing by and forwards it through its token register.
// ----------------------------------------------------------------------------
module ptt_cell
	import ptt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   stall,
	input  token_t tok_in,
	output token_t tok_out,
	output fire_t  fire
);

	logic                 valid_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [ID_W-1:0]      id_q;
	logic [HANDLER_W-1:0] handler_q;
	logic [NOW_W-1:0]     last_q;

	logic                 tok_vld_q;
	token_t               tok_q;
	token_t               tok_next;

	logic [NOW_W:0]       elapsed;
	logic                 due;
	logic                 is_tick;
	logic                 do_stamp;
	logic                 do_fire;
	logic                 do_take;
	logic                 do_match;
	logic                 advance;

	// Elapsed time with borrow; a borrow means time went backward
	assign elapsed = {1'b0, tok_in.now_ms} - {1'b0, last_q};
	assign due     = !elapsed[NOW_W] &&
	                 (elapsed[NOW_W-1:0] >= {{(NOW_W-PERIOD_W){1'b0}}, period_q});

	assign is_tick  = tok_in.valid && (tok_in.cmd == CMD_TICK);
	assign do_stamp = is_tick && tok_in.stamp && valid_q;
	assign do_fire  = is_tick && !tok_in.stamp && valid_q && due;
	assign do_take  = tok_in.valid && (tok_in.cmd == CMD_ADD) && !tok_in.flag && !valid_q;
	assign do_match = tok_in.valid && (tok_in.cmd == CMD_DEL) && valid_q &&
	                  (period_q == tok_in.period_ms) && (id_q == tok_in.timer_id) &&
	                  (handler_q == tok_in.handler_tag);
	assign advance  = !stall;

	assign fire.fire    = do_fire;
	assign fire.id      = do_fire ? id_q : '0;
	assign fire.handler = do_fire ? handler_q : '0;

	// Mark the token once this slot took the add or cleared on delete
	always_comb begin
		tok_next      = tok_in;
		tok_next.flag = tok_in.flag | do_take | do_match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			tok_vld_q <= 1'b0;
		end else if (advance) begin
			tok_vld_q <= tok_in.valid;
			if (do_take) begin
				valid_q <= 1'b1;
			end else if (do_match) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_q <= tok_next;
			if (do_take) begin
				period_q  <= tok_in.period_ms;
				id_q      <= tok_in.timer_id;
				handler_q <= tok_in.handler_tag;
				last_q    <= '0;
			end else if (do_stamp || do_fire) begin
				last_q <= tok_in.now_ms;
			end
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_vld_q;
	end

endmodule

// ===== sv/periodic_timer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timers built as a row of slot cells.
// ----------------------------------------------------------------------------
// The table holds SLOTS timers, one per cell of a row. Each accepted request
// (tick, add or delete) becomes a token that walks the row one cell per
// cycle while the row is not stalled; each cell acts on its own slot as the
// token passes: add claims the first free slot, delete clears every matching
// slot, and tick fires every due timer in slot order (the first tick only
// stamps the held timers). A request passes the head register, SLOTS cells
// and the result register; the row freezes while a pending result stalls.
// One request is in the row at a time; a request with command three is
// accepted and dropped without any result. The result register sits between
// the row and the rsp channel, so a new request is taken while the last
// result of the previous one still waits.
// ----------------------------------------------------------------------------
module periodic_timer_table
	import ptt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
)(
	input  logic clk,
	input  logic arst_n,
	ptt_stream_if.sink   req,
	ptt_stream_if.source rsp
);

	// Token wires: tok[0] is the head register, tok[SLOTS] the tail
	token_t tok [SLOTS+1];
	fire_t  fires [SLOTS];

	logic   head_vld_q;
	token_t head_q;
	logic   busy_q;
	logic   started_q;
	logic   rsp_valid_q;
	rsp_t   rsp_q;

	logic                 accept;
	logic                 launch;
	logic                 out_free;
	logic                 stall;
	logic                 fire_any;
	logic [ID_W-1:0]      fire_id;
	logic [HANDLER_W-1:0] fire_handler;
	logic                 final_load;
	logic [KIND_W-1:0]    final_kind;
	logic [SLOTS:0]       tok_vld;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	// Command three is consumed without entering the row
	assign launch    = accept && (req.data.cmd == CMD_TICK || req.data.cmd == CMD_ADD ||
	                              req.data.cmd == CMD_DEL);

	// Result register frees up when empty or being taken this cycle
	assign out_free   = !rsp_valid_q || rsp.ready;
	// Freeze the whole row while a result has nowhere to go
	assign stall      = (fire_any || tok[SLOTS].valid) && !out_free;
	assign final_load = tok[SLOTS].valid && out_free;

	// Head register: hold the new token until cell zero takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			busy_q     <= 1'b0;
			started_q  <= 1'b0;
		end else begin
			if (launch) begin
				head_vld_q <= 1'b1;
			end else if (!stall) begin
				head_vld_q <= 1'b0;
			end
			if (launch) begin
				busy_q <= 1'b1;
			end else if (final_load) begin
				busy_q <= 1'b0;
			end
			if (accept && req.data.cmd == CMD_TICK) begin
				started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			head_q.valid       <= 1'b1;
			head_q.cmd         <= req.data.cmd;
			head_q.stamp       <= !started_q;
			head_q.flag        <= 1'b0;
			head_q.now_ms      <= req.data.now_ms;
			head_q.period_ms   <= req.data.period_ms;
			head_q.timer_id    <= req.data.timer_id;
			head_q.handler_tag <= req.data.handler_tag;
		end
	end

	always_comb begin
		tok[0]       = head_q;
		tok[0].valid = head_vld_q;
	end

	// Row of slot cells
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		ptt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.stall   (stall),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1]),
			.fire    (fires[g])
		);
	end

	// Only the cell holding the token can fire, so an OR picks the report
	always_comb begin
		fire_any     = 1'b0;
		fire_id      = '0;
		fire_handler = '0;
		for (int i = 0; i < SLOTS; i++) begin
			fire_any     = fire_any | fires[i].fire;
			fire_id      = fire_id | fires[i].id;
			fire_handler = fire_handler | fires[i].handler;
		end
	end

	// Final answer from the token that left the row
	always_comb begin
		case (tok[SLOTS].cmd)
			CMD_TICK: final_kind = KIND_TICK_DONE;
			CMD_ADD:  final_kind = tok[SLOTS].flag ? KIND_ADDED : KIND_FULL;
			CMD_DEL:  final_kind = tok[SLOTS].flag ? KIND_DELETED : KIND_NOMATCH;
			default:  final_kind = KIND_TICK_DONE;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= fire_any || tok[SLOTS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (fire_any) begin
				rsp_q.kind          <= KIND_FIRED;
				rsp_q.fired_id      <= fire_id;
				rsp_q.fired_handler <= fire_handler;
				rsp_q.last          <= 1'b0;
			end else if (tok[SLOTS].valid) begin
				rsp_q.kind          <= final_kind;
				rsp_q.fired_id      <= '0;
				rsp_q.fired_handler <= '0;
				rsp_q.last          <= 1'b1;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_comb begin
		for (int i = 0; i <= SLOTS; i++) begin
			tok_vld[i] = tok[i].valid;
		end
	end

	// At most one request walks the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one token in the cell row");

	// An idle table has an empty row
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tok_vld == '0))
		else $error("token in the row while not busy");

	// A firing cell and the tail never compete for the result register
	a_fire_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire_any && tok[SLOTS].valid))
		else $error("fire and final result in the same cycle");

	// Loading the final result ends the request
	a_final_done: assert property (@(posedge clk) disable iff (!arst_n)
		final_load |=> !busy_q && rsp_valid_q && rsp_q.last)
		else $error("final result did not release the table");

	// A fired report never carries the last mark
	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_any && out_free) |=> rsp_valid_q && !rsp_q.last && rsp_q.kind == KIND_FIRED)
		else $error("fired report loaded wrongly");

endmodule
